[src/evs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder velocity estimator package
// Widths, reset values and item types shared by the estimator modules.
// ----------------------------------------------------------------------------
package evs_pkg;

  localparam int TS_W = 32;
  localparam int RATE_W = 27;
  localparam int VEL_W = 40;
  localparam int MAG_W = VEL_W + 1;
  localparam int NUM_W = TS_W + RATE_W;

  localparam int FRACTION_BITS_DEF = 8;
  localparam int WRAP_SPAN_DEF = 65535;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000000);

  localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

  typedef struct packed {
    logic [31:0]        timer_now;
    logic signed [15:0] wraps_a;
    logic [15:0]        counter_a;
    logic [31:0]        edge_time_a;
    logic signed [15:0] wraps_b;
    logic [15:0]        counter_b;
    logic [31:0]        edge_time_b;
  } in_item_t;

  typedef struct packed {
    logic signed [39:0] velocity_a;
    logic signed [39:0] velocity_b;
    logic               zero_span_a;
    logic               zero_span_b;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic done;
    logic overflow;
  } div_status_t;

endpackage

[src/evs_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring division, one quotient bit per cycle; keeps the low quotient bits
// and a sticky flag for any quotient bit that falls above them.
// ----------------------------------------------------------------------------
module evs_div #(
  parameter int DIVIDEND_W = evs_pkg::NUM_W + evs_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [DIVIDEND_W-1:0]       dividend,
  input  logic [evs_pkg::TS_W-1:0]    divisor,
  output logic [evs_pkg::MAG_W-1:0]   quotient,
  output evs_pkg::div_status_t        status
);
  import evs_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DIVIDEND_W-1:0] dvd;
  logic [TS_W-1:0]  dvs;
  logic [TS_W-1:0]  rem;
  logic [MAG_W-1:0] quo;
  logic             ovf;
  logic [TS_W:0]    trial;
  logic             fits;
  logic [TS_W:0]    diff;

  always_comb begin
    trial = {rem, dvd[DIVIDEND_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
      quo <= '0;
      ovf <= 1'b0;
    end else if (busy) begin
      dvd <= dvd << 1;
      rem <= fits ? diff[TS_W-1:0] : trial[TS_W-1:0];
      quo <= {quo[MAG_W-2:0], fits};
      ovf <= ovf | quo[MAG_W-1];
    end
  end

  assign quotient        = quo;
  assign status.done     = done;
  assign status.overflow = ovf;

endmodule

[src/encoder_velocity_estimator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder velocity estimator
// Two-wheel velocity from encoder position and edge timing, one result per
// sample tick, with a single bit-serial divider shared by both wheels.
// ----------------------------------------------------------------------------
// Each item passes through the shared divider for wheel A and then wheel B,
// one quotient bit per cycle; the next item is taken once the result has
// moved into the output register.
// Reset clears the history of both wheels and loads the tick rate with 1000000.
module encoder_velocity_estimator_top #(
  parameter int FRACTION_BITS = evs_pkg::FRACTION_BITS_DEF,
  parameter int WRAP_SPAN     = evs_pkg::WRAP_SPAN_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  evs_pkg::in_item_t          in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output evs_pkg::out_item_t         out_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [evs_pkg::RATE_W-1:0] cfg_data
);
  import evs_pkg::*;

  localparam int DIVIDEND_W = NUM_W + FRACTION_BITS;
  localparam logic [TS_W-1:0] SPAN32 = TS_W'(WRAP_SPAN);
  localparam logic [MAG_W-1:0] MAG_NEG = {2'b01, {(MAG_W-2){1'b0}}};
  localparam logic [MAG_W-1:0] MAG_POS = {2'b00, {(MAG_W-2){1'b1}}};

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_POS  = 8'b0000_0010,
    S_DIFF = 8'b0000_0100,
    S_DEN  = 8'b0000_1000,
    S_MUL  = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_END  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t state;
  logic   wheel;

  logic [RATE_W-1:0] rate;
  logic [TS_W-1:0]   last_timestamp;
  logic [TS_W-1:0]   last_position [2];
  logic [TS_W-1:0]   last_edge_offset [2];
  logic [TS_W-1:0]   stale_time [2];

  in_item_t         item;
  logic [TS_W-1:0]  dt;
  logic [TS_W-1:0]  pos;
  logic [TS_W-1:0]  offs;
  logic [TS_W-1:0]  dpos;
  logic [TS_W-1:0]  denom;
  logic [TS_W-1:0]  dmag;
  logic             neg;
  logic             zero;
  logic [VEL_W-1:0] vel_a;
  logic [VEL_W-1:0] vel_b;
  logic             zero_a;
  logic             zero_b;
  logic             sat;

  logic [15:0]      wr_sel;
  logic [15:0]      cnt_sel;
  logic [TS_W-1:0]  edge_sel;
  logic [TS_W-1:0]  ws_ext;
  logic [TS_W-1:0]  pos_calc;
  logic [NUM_W-1:0] num;
  logic [DIVIDEND_W-1:0] dividend;
  logic [TS_W-1:0]  den_mag;
  logic             div_start;
  logic [MAG_W-1:0] quotient;
  div_status_t      div_stat;

  logic [VEL_W-1:0] vel_res;
  logic             zero_res;
  logic             sat_res;
  logic             in_take;
  logic             out_load;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_load  = (state == S_OUT) && (!out_valid || !out_stall);
  assign div_start = (state == S_MUL);

  always_comb begin
    wr_sel   = wheel ? item.wraps_b : item.wraps_a;
    cnt_sel  = wheel ? item.counter_b : item.counter_a;
    edge_sel = wheel ? item.edge_time_b : item.edge_time_a;
    ws_ext   = {{16{wr_sel[15]}}, wr_sel};
    pos_calc = ws_ext * SPAN32 + {16'b0, cnt_sel};
    num      = NUM_W'(dmag) * NUM_W'(rate);
    dividend = DIVIDEND_W'(num) << FRACTION_BITS;
    den_mag  = denom[TS_W-1] ? (TS_W'(0) - denom) : denom;
  end

  always_comb begin
    vel_res  = '0;
    zero_res = 1'b0;
    sat_res  = 1'b0;
    if (zero) begin
      zero_res = 1'b1;
    end else if (neg) begin
      if (div_stat.overflow || quotient > MAG_NEG) begin
        vel_res = VEL_MIN;
        sat_res = 1'b1;
      end else begin
        vel_res = VEL_W'(MAG_W'(0) - quotient);
      end
    end else begin
      if (div_stat.overflow || quotient > MAG_POS) begin
        vel_res = VEL_MAX;
        sat_res = 1'b1;
      end else begin
        vel_res = quotient[VEL_W-1:0];
      end
    end
  end

  evs_div #(
    .DIVIDEND_W(DIVIDEND_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (den_mag),
    .quotient (quotient),
    .status   (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      wheel               <= 1'b0;
      rate                <= RATE_RESET;
      last_timestamp      <= '0;
      last_position[0]    <= '0;
      last_position[1]    <= '0;
      last_edge_offset[0] <= '0;
      last_edge_offset[1] <= '0;
      stale_time[0]       <= '0;
      stale_time[1]       <= '0;
      out_valid           <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        rate <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            last_timestamp <= in_item.timer_now;
            wheel          <= 1'b0;
            state          <= S_POS;
          end
        end
        S_POS: begin
          state <= S_DIFF;
        end
        S_DIFF: begin
          stale_time[wheel]    <= (pos == last_position[wheel]) ?
                                  stale_time[wheel] + dt : dt;
          last_position[wheel] <= pos;
          state                <= S_DEN;
        end
        S_DEN: begin
          last_edge_offset[wheel] <= offs;
          state                   <= S_MUL;
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_END;
          end
        end
        S_END: begin
          if (wheel) begin
            state <= S_OUT;
          end else begin
            wheel <= 1'b1;
            state <= S_POS;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item <= in_item;
      dt   <= in_item.timer_now - last_timestamp;
      sat  <= 1'b0;
    end
    if (state == S_POS) begin
      pos  <= pos_calc;
      offs <= item.timer_now - edge_sel;
    end
    if (state == S_DIFF) begin
      dpos <= pos - last_position[wheel];
    end
    if (state == S_DEN) begin
      denom <= stale_time[wheel] + last_edge_offset[wheel] - offs;
      dmag  <= dpos[TS_W-1] ? (TS_W'(0) - dpos) : dpos;
    end
    if (state == S_MUL) begin
      neg  <= dpos[TS_W-1] ^ denom[TS_W-1];
      zero <= (denom == '0);
    end
    if (state == S_END) begin
      sat <= sat | sat_res;
      if (wheel) begin
        vel_b  <= vel_res;
        zero_b <= zero_res;
      end else begin
        vel_a  <= vel_res;
        zero_a <= zero_res;
      end
    end
    if (out_load) begin
      out_item.velocity_a  <= vel_a;
      out_item.velocity_b  <= vel_b;
      out_item.zero_span_a <= zero_a;
      out_item.zero_span_b <= zero_b;
      out_item.saturated   <= sat;
    end
  end

endmodule

[src/evs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder velocity estimator checker
// Port-level properties of the estimator, bound to its top level.
// ----------------------------------------------------------------------------
module evs_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input evs_pkg::out_item_t         out_item
);
  import evs_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown straight after reset");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken while the first is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed or dropped");

  a_zero_span: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.zero_span_a) |-> (out_item.velocity_a == '0))
    else $error("zero span on wheel A with a non-zero speed");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.saturated) |->
      (out_item.velocity_a == VEL_MAX || out_item.velocity_a == VEL_MIN ||
       out_item.velocity_b == VEL_MAX || out_item.velocity_b == VEL_MIN))
    else $error("saturation flagged with no speed at a limit");

endmodule

bind encoder_velocity_estimator_top evs_checker u_evs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

[dv/encoder_velocity_estimator_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder velocity estimator testbench
// Drives timestamped two-wheel encoder samples through the estimator, first a
// directed set and then random motion sequences under several tick rates. A
// scoreboard predicts each wheel's velocity and zero-span flag, the clipping
// flag, and checks them in every result. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module encoder_velocity_estimator_top_test;
  import evs_pkg::*;

  class velocity_scoreboard;
    logic [RATE_W-1:0] rate;
    logic [31:0]       last_ts;
    logic [31:0]       last_pos[2];
    logic [31:0]       last_offs[2];
    logic [31:0]       stale[2];
    out_item_t         expected_q[$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       zero_spans;
    int unsigned       clipped;

    function new();
      rate = RATE_RESET;
      last_ts = '0;
      last_pos = '{32'd0, 32'd0};
      last_offs = '{32'd0, 32'd0};
      stale = '{32'd0, 32'd0};
      errors = 0;
      checked = 0;
      zero_spans = 0;
      clipped = 0;
    endfunction

    function logic [31:0] position(logic signed [15:0] wraps, logic [15:0] counter);
      logic [31:0] wide;
      wide = {{16{wraps[15]}}, wraps};
      return wide * 32'(WRAP_SPAN_DEF) + {16'h0000, counter};
    endfunction

    function logic [31:0] magnitude(logic [31:0] v);
      return v[31] ? -v : v;
    endfunction

    function void wheel(int w, logic [31:0] now, logic [31:0] dt,
                        logic signed [15:0] wraps, logic [15:0] counter,
                        logic [31:0] edge_ts, output logic [39:0] vel,
                        output logic zero, inout logic sat);
      logic [31:0] pos, dpos, offs, denom;
      logic [63:0] num, dmag, quo, rem, mag, neg_mag;
      pos = position(wraps, counter);
      dpos = pos - last_pos[w];
      offs = now - edge_ts;
      stale[w] = (dpos == 32'd0) ? stale[w] + dt : dt;
      denom = stale[w] + last_offs[w] - offs;
      vel = '0;
      zero = 1'b0;
      if (denom == 32'd0) begin
        zero = 1'b1;
      end else begin
        num = 64'(magnitude(dpos)) * 64'(rate);
        dmag = 64'(magnitude(denom));
        quo = num / dmag;
        rem = num % dmag;
        if (quo >= (64'd1 << VEL_W)) begin
          mag = 64'(VEL_MIN) + 64'd1;
        end else begin
          mag = (quo << FRACTION_BITS_DEF) + ((rem << FRACTION_BITS_DEF) / dmag);
        end
        if (dpos[31] ^ denom[31]) begin
          if (mag > 64'(VEL_MIN)) begin
            mag = 64'(VEL_MIN);
            sat = 1'b1;
          end
          neg_mag = -mag;
          vel = neg_mag[39:0];
        end else begin
          if (mag > 64'(VEL_MAX)) begin
            mag = 64'(VEL_MAX);
            sat = 1'b1;
          end
          vel = mag[39:0];
        end
      end
      last_pos[w] = pos;
      last_offs[w] = offs;
    endfunction

    function void note_input(in_item_t it);
      out_item_t   exp_item;
      logic [31:0] dt;
      logic [39:0] vel_a, vel_b;
      logic        zero_a, zero_b, sat;
      dt = it.timer_now - last_ts;
      sat = 1'b0;
      wheel(0, it.timer_now, dt, it.wraps_a, it.counter_a, it.edge_time_a, vel_a, zero_a, sat);
      wheel(1, it.timer_now, dt, it.wraps_b, it.counter_b, it.edge_time_b, vel_b, zero_b, sat);
      exp_item.velocity_a = vel_a;
      exp_item.velocity_b = vel_b;
      exp_item.zero_span_a = zero_a;
      exp_item.zero_span_b = zero_b;
      exp_item.saturated = sat;
      last_ts = it.timer_now;
      expected_q.push_back(exp_item);
    endfunction

    task report(string what);
      if (errors < 30) $display("ERROR at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t exp_item;
      if (expected_q.size() == 0) begin
        report("result arrived with no item outstanding");
        return;
      end
      exp_item = expected_q.pop_front();
      checked++;
      if (exp_item.zero_span_a || exp_item.zero_span_b) zero_spans++;
      if (exp_item.saturated) clipped++;
      if (got.velocity_a !== exp_item.velocity_a)
        report($sformatf("velocity_a got %h, want %h", got.velocity_a, exp_item.velocity_a));
      if (got.velocity_b !== exp_item.velocity_b)
        report($sformatf("velocity_b got %h, want %h", got.velocity_b, exp_item.velocity_b));
      if (got.zero_span_a !== exp_item.zero_span_a)
        report($sformatf("zero_span_a got %b, want %b", got.zero_span_a, exp_item.zero_span_a));
      if (got.zero_span_b !== exp_item.zero_span_b)
        report($sformatf("zero_span_b got %b, want %b", got.zero_span_b, exp_item.zero_span_b));
      if (got.saturated !== exp_item.saturated)
        report($sformatf("saturated got %b, want %b", got.saturated, exp_item.saturated));
    endtask

    task check_drained();
      if (expected_q.size() != 0)
        report($sformatf("%0d results never arrived", expected_q.size()));
    endtask
  endclass

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 125;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_item;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_item;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [RATE_W-1:0] cfg_data;

  velocity_scoreboard sb = new();
  bit                 idle_on = 1'b1;
  int unsigned        items_sent = 0;
  int unsigned        rates_written = 0;
  logic signed [15:0] trk_wraps[2];
  logic [15:0]        trk_counter[2];
  logic [RATE_W-1:0]  rate_plan[6];

  encoder_velocity_estimator_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic push_item(input in_item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    items_sent++;
    trk_wraps[0] = it.wraps_a;
    trk_wraps[1] = it.wraps_b;
    trk_counter[0] = it.counter_a;
    trk_counter[1] = it.counter_b;
  endtask

  task automatic push_fields(input logic [31:0] now,
                             input logic signed [15:0] wa, input logic [15:0] ca,
                             input logic [31:0] ea,
                             input logic signed [15:0] wb, input logic [15:0] cb,
                             input logic [31:0] eb);
    in_item_t it;
    it.timer_now = now;
    it.wraps_a = wa;
    it.counter_a = ca;
    it.edge_time_a = ea;
    it.wraps_b = wb;
    it.counter_b = cb;
    it.edge_time_b = eb;
    push_item(it);
  endtask

  task automatic stop_items();
    in_valid <= 1'b0;
  endtask

  task automatic wait_results_drained();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_tick_rate(input logic [RATE_W-1:0] value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.rate = value;
    rates_written++;
  endtask

  function automatic in_item_t next_motion_item();
    in_item_t    it;
    logic [31:0] dt, pos, stale_next;
    logic [31:0] edge_ts[2];
    int          delta, cnt, sel;
    if ($urandom_range(0, 99) < 12) begin
      it = {$urandom, $urandom, $urandom, $urandom, $urandom};
      return it;
    end
    case ($urandom_range(0, 9))
      0: dt = 32'd0;
      1: dt = $urandom;
      2: dt = $urandom_range(1, 1 << 20);
      default: dt = $urandom_range(1, 5000);
    endcase
    it.timer_now = sb.last_ts + dt;
    for (int w = 0; w < 2; w++) begin
      sel = $urandom_range(0, 19);
      delta = 0;
      if (sel >= 8 && sel < 17) begin
        delta = int'($urandom_range(0, 100)) - 50;
      end else if (sel < 19 && sel >= 17) begin
        delta = int'($urandom_range(0, 2000000)) - 1000000;
      end else if (sel == 19) begin
        trk_wraps[w] = 16'($urandom);
        trk_counter[w] = 16'($urandom);
      end
      cnt = int'(trk_counter[w]) + delta;
      while (cnt > 65535) begin
        cnt -= 65535;
        trk_wraps[w] = trk_wraps[w] + 16'sd1;
      end
      while (cnt < 0) begin
        cnt += 65535;
        trk_wraps[w] = trk_wraps[w] - 16'sd1;
      end
      trk_counter[w] = cnt[15:0];
      pos = sb.position(trk_wraps[w], trk_counter[w]);
      stale_next = (pos == sb.last_pos[w]) ? sb.stale[w] + dt : dt;
      sel = $urandom_range(0, 19);
      if (sel < 3) edge_ts[w] = it.timer_now - (stale_next + sb.last_offs[w]);
      else if (sel < 5) edge_ts[w] = it.timer_now;
      else if (sel < 7) edge_ts[w] = $urandom;
      else edge_ts[w] = it.timer_now - $urandom_range(0, 3000);
    end
    it.wraps_a = trk_wraps[0];
    it.counter_a = trk_counter[0];
    it.edge_time_a = edge_ts[0];
    it.wraps_b = trk_wraps[1];
    it.counter_b = trk_counter[1];
    it.edge_time_b = edge_ts[1];
    return it;
  endfunction

  initial begin : receiver
    int burst;
    burst = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.check_result(out_item);
      if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("encoder_velocity_estimator_top: mismatch");
    $finish;
  end

  initial begin : stimulus
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    trk_wraps = '{16'sd0, 16'sd0};
    trk_counter = '{16'd0, 16'd0};
    rate_plan = '{27'd1, 27'h7FF_FFFF, 27'd0, 27'd100000000, 27'd0, 27'd1000};
    rate_plan[4] = RATE_W'($urandom_range(2, 100000000));
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    push_fields(32'd0, 16'sd0, 16'd0, 32'd0, 16'sd0, 16'd0, 32'd0);
    push_fields(32'd100, 16'sd0, 16'd10, 32'd95, 16'sd0, 16'd0, 32'd0);
    push_fields(32'd200, 16'sd0, 16'd10, 32'd95, -16'sd1, 16'd65534, 32'd150);
    push_fields(32'd300, 16'sd0, 16'd10, 32'd95, -16'sd1, 16'd65534, 32'd150);
    push_fields(32'd301, 16'sd0, 16'd30010, 32'd301, -16'sd2, 16'd0, 32'd301);
    push_fields(32'hFFFF_FFFF, 16'sd32767, 16'hFFFF, 32'hFFFF_FFFF,
                -16'sd32768, 16'd0, 32'd0);
    push_fields(32'd0, -16'sd32768, 16'd0, 32'd0, 16'sd32767, 16'hFFFF, 32'hFFFF_FFFF);
    push_fields(32'd1000, -16'sd32768, 16'd5, 32'd500, 16'sd32767, 16'hFFFE,
                32'hF000_0000);
    push_fields(32'd1500, -16'sd32768, 16'd5, 32'd500, 16'sd32767, 16'hFFFE,
                32'hF000_0000);
    push_fields(32'hAAAA_AAAA, 16'sh5555, 16'hAAAA, 32'h5555_5555,
                16'shAAAA, 16'h5555, 32'hAAAA_AAAA);
    push_fields(32'h5555_5555, 16'shAAAA, 16'h5555, 32'hAAAA_AAAA,
                16'sh5555, 16'hAAAA, 32'h5555_5555);
    push_fields(32'h5555_5556, 16'shAAAA, 16'h5556, 32'h5555_5556,
                16'sh5555, 16'hAAA9, 32'h5555_5556);

    for (int p = 0; p < 6; p++) begin
      stop_items();
      wait_results_drained();
      write_tick_rate(rate_plan[p]);
      idle_on = (p != 5);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 49) == 0) begin
          stop_items();
          wait_results_drained();
        end
        push_item(next_motion_item());
      end
    end

    stop_items();
    wait_results_drained();
    repeat (200) @(posedge clk);
    sb.check_drained();
    $display("Sent %0d items across %0d tick-rate settings; %0d results compared.",
             items_sent, rates_written + 1, sb.checked);
    $display("Of these, %0d had a zero span on a wheel and %0d were clipped.",
             sb.zero_spans, sb.clipped);
    if (sb.errors == 0) begin
      $display("encoder_velocity_estimator_top: match");
    end else begin
      $display("encoder_velocity_estimator_top: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
src/evs_pkg.sv
src/evs_div.sv
src/encoder_velocity_estimator_top.sv
src/evs_checker.sv
dv/encoder_velocity_estimator_top_test.sv
